// ===== sv/biq_pkg.sv =====
// Shared types, constants and the control-store contents for the biquad IIR filter.
// Used by every module of the filter. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package biq_pkg;

    // Fixed widths of the coefficient and delay registers, the coefficient count and index widths.
    localparam int COEF_W   = 18;
    localparam int DELAY_W  = 48;
    localparam int NUM_COEF = 5;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W   = 3;

    // Register index of each coefficient. This is also the multiplier select code.
    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_idx_t;

    // Accumulator base operand.
    typedef enum logic [1:0] {
        ACC_ZERO = 2'd0,
        ACC_HOLD = 2'd1,
        ACC_D1   = 2'd2,
        ACC_D2   = 2'd3
    } acc_src_t;

    // One control word of the microprogram.
    typedef struct packed {
        acc_src_t  acc_src;  // base added to the product
        coef_idx_t coef_sel; // coefficient fed to the multiplier
        logic      mul_y;    // multiply the output sample instead of the input
        logic      sub;      // subtract the product instead of adding it
        logic      emit;     // round and saturate the accumulator, hand the result out
        logic      wr_d1;    // write the clamped accumulator into the first delay
        logic      wr_d2;    // write the clamped accumulator into the second delay
        logic      last;     // final step: return to idle
    } cw_t;

    // Sequencer to datapath control bundle.
    typedef struct packed {
        logic start;   // an input transfer happens this cycle
        logic step_en; // the control word below executes this cycle
        cw_t  cw;
    } ctrl_t;

    localparam int NUM_STEPS = 6;

    // Microprogram for one sample.
    //   0: acc = d1 + b0*x
    //   1: y = sat(round(acc)), acc = d2 + b1*x
    //   2: acc = acc - a1*y
    //   3: d1 = clamp(acc), acc = b2*x
    //   4: acc = acc - a2*y
    //   5: d2 = clamp(acc), done
    function automatic cw_t ucode(input logic [STEP_W-1:0] step);
        cw_t w;
        w = '{acc_src: ACC_HOLD, coef_sel: COEF_B0, mul_y: 1'b0, sub: 1'b0,
              emit: 1'b0, wr_d1: 1'b0, wr_d2: 1'b0, last: 1'b0};
        case (step)
            3'd0: begin
                w.acc_src  = ACC_D1;
                w.coef_sel = COEF_B0;
            end
            3'd1: begin
                w.acc_src  = ACC_D2;
                w.coef_sel = COEF_B1;
                w.emit     = 1'b1;
            end
            3'd2: begin
                w.acc_src  = ACC_HOLD;
                w.coef_sel = COEF_A1;
                w.mul_y    = 1'b1;
                w.sub      = 1'b1;
            end
            3'd3: begin
                w.acc_src  = ACC_ZERO;
                w.coef_sel = COEF_B2;
                w.wr_d1    = 1'b1;
            end
            3'd4: begin
                w.acc_src  = ACC_HOLD;
                w.coef_sel = COEF_A2;
                w.mul_y    = 1'b1;
                w.sub      = 1'b1;
            end
            3'd5: begin
                w.wr_d2    = 1'b1;
                w.last     = 1'b1;
            end
            default: begin
                w.last     = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/biq_useq.sv =====
// Microcode sequencer of the biquad filter: step counter, control store and stall logic.
// Depends on biq_pkg for the control word and the microprogram.
`timescale 1ns / 1ps
`default_nettype none

module biq_useq
    import biq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,     // input transfer this cycle
    input  wire logic out_full,  // output register holds a result that is not taken
    output logic      busy,
    output ctrl_t     ctrl
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    cw_t               cw;
    logic              hold;
    logic              step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_comb begin
        cw        = ucode(step_reg);
        // A result step waits while the output register is still occupied.
        hold      = cw.emit && out_full;
        step_en   = busy_reg && !hold;
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (step_en) begin
            if (cw.last) begin
                busy_next = 1'b0;
                step_next = '0;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    assign busy = busy_reg;
    assign ctrl = '{start: start, step_en: step_en, cw: cw};

endmodule

`default_nettype wire

// ===== sv/biq_datapath.sv =====
// Datapath of the biquad filter: coefficient registers, shared multiply-accumulate,
// delay registers, rounding and saturation. Depends on biq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module biq_datapath
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]           cfg_addr,
    input  wire logic [COEF_W-1:0]              cfg_wdata,
    input  wire ctrl_t                          ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  wire logic                           block_start,
    output logic signed [SAMPLE_WIDTH-1:0]      y_sat,
    output logic                                y_clip
);

    localparam int PROD_W = COEF_W + SAMPLE_WIDTH;
    localparam int ACC_W  = ((PROD_W > DELAY_W) ? PROD_W : DELAY_W) + 3;

    localparam logic signed [ACC_W-1:0] SMAX =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] DMAX =
        {{(ACC_W-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DMIN =
        {{(ACC_W-DELAY_W+1){1'b1}}, {(DELAY_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    // Unity gain, or the largest coefficient when unity does not fit.
    localparam logic signed [COEF_W-1:0] B0_RESET = (COEF_FRAC_BITS >= COEF_W - 1) ?
        {1'b0, {(COEF_W-1){1'b1}}} : COEF_W'(1 << COEF_FRAC_BITS);

    logic signed [COEF_W-1:0]       coef_reg [NUM_COEF];
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [DELAY_W-1:0]      d1_reg, d2_reg;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;

    logic signed [COEF_W-1:0]       coef_op;
    logic signed [SAMPLE_WIDTH-1:0] mul_op;
    logic signed [PROD_W-1:0]       prod;
    logic signed [ACC_W-1:0]        base;
    logic signed [ACC_W-1:0]        rnd;
    logic signed [ACC_W-1:0]        rnd_int;
    logic signed [DELAY_W-1:0]      d_clamped;

    // Coefficient registers; indexes past the last coefficient are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[COEF_B0] <= B0_RESET;
            coef_reg[COEF_B1] <= '0;
            coef_reg[COEF_B2] <= '0;
            coef_reg[COEF_A1] <= '0;
            coef_reg[COEF_A2] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                COEF_B0: coef_reg[COEF_B0] <= cfg_wdata;
                COEF_B1: coef_reg[COEF_B1] <= cfg_wdata;
                COEF_B2: coef_reg[COEF_B2] <= cfg_wdata;
                COEF_A1: coef_reg[COEF_A1] <= cfg_wdata;
                COEF_A2: coef_reg[COEF_A2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ctrl.cw.coef_sel)
            COEF_B0: coef_op = coef_reg[COEF_B0];
            COEF_B1: coef_op = coef_reg[COEF_B1];
            COEF_B2: coef_op = coef_reg[COEF_B2];
            COEF_A1: coef_op = coef_reg[COEF_A1];
            COEF_A2: coef_op = coef_reg[COEF_A2];
            default: coef_op = '0;
        endcase
        mul_op = ctrl.cw.mul_y ? y_reg : x_reg;
        prod   = coef_op * mul_op;
        case (ctrl.cw.acc_src)
            ACC_ZERO: base = '0;
            ACC_HOLD: base = acc_reg;
            ACC_D1:   base = ACC_W'(d1_reg);
            ACC_D2:   base = ACC_W'(d2_reg);
            default:  base = '0;
        endcase
        acc_next = ctrl.cw.sub ? (base - ACC_W'(prod)) : (base + ACC_W'(prod));

        // Round half up, then saturate to the sample width.
        rnd     = acc_reg + HALF;
        rnd_int = rnd >>> COEF_FRAC_BITS;
        if (rnd_int > SMAX) begin
            y_sat  = SMAX[SAMPLE_WIDTH-1:0];
            y_clip = 1'b1;
        end else if (rnd_int < SMIN) begin
            y_sat  = SMIN[SAMPLE_WIDTH-1:0];
            y_clip = 1'b1;
        end else begin
            y_sat  = rnd_int[SAMPLE_WIDTH-1:0];
            y_clip = 1'b0;
        end

        if (acc_reg > DMAX) begin
            d_clamped = DMAX[DELAY_W-1:0];
        end else if (acc_reg < DMIN) begin
            d_clamped = DMIN[DELAY_W-1:0];
        end else begin
            d_clamped = acc_reg[DELAY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            x_reg <= sample_in;
        end
        if (ctrl.step_en) begin
            acc_reg <= acc_next;
        end
        if (ctrl.step_en && ctrl.cw.emit) begin
            y_reg <= y_sat;
        end
    end

    // Filter state: cleared by reset and by a block start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else if (ctrl.start) begin
            if (block_start) begin
                d1_reg <= '0;
                d2_reg <= '0;
            end
        end else if (ctrl.step_en) begin
            if (ctrl.cw.wr_d1) begin
                d1_reg <= d_clamped;
            end
            if (ctrl.cw.wr_d2) begin
                d2_reg <= d_clamped;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/biquad_iir_filter.sv =====
// Biquad IIR section, transposed direct form II, one shared multiply-accumulate.
// Path: the input sample is registered, step 0 accumulates, and step 1 rounds the result into
// the output register behind m_tvalid once it is free. A new sample is taken only after six
// microprogram steps for the five taps on the single multiplier; an untaken result stalls.
// Reset: aresetn is synchronous, active low; it clears both delays, loads b0 with unity
// and the other coefficients with zero, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module biquad_iir_filter
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Configuration write port. Index 0..4 selects b0, b1, b2, a1, a2.
    input  wire logic                                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]                 cfg_addr,
    input  wire logic [COEF_W-1:0]                    cfg_wdata,
    // Input stream.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // sample_in
    input  wire logic                                 s_tuser,  // block_start
    // Result stream.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata,  // sample_out
    output logic                                      m_tuser   // clipped
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    logic                           busy;
    logic                           start;
    ctrl_t                          ctrl;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           y_clip;

    // Output register, so that a finished result never blocks the next input transfer.
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] out_y_reg;
    logic                    out_clip_reg;
    logic                    out_load;
    logic                    out_full;

    // The block takes a new sample whenever the sequencer is idle, even while the
    // previous result still waits in the output register.
    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;

    // The result step of the microprogram stalls while the register is still full.
    assign out_full = out_valid_reg && !m_tready;

    biq_useq u_useq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_full (out_full),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    biq_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .ctrl        (ctrl),
        .sample_in   (s_tdata[SAMPLE_WIDTH-1:0]),
        .block_start (s_tuser),
        .y_sat       (y_sat),
        .y_clip      (y_clip)
    );

    // The result enters the output register on the step that rounds the accumulator.
    assign out_load       = ctrl.step_en && ctrl.cw.emit;
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_y_reg    <= y_sat;
            out_clip_reg <= y_clip;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_y_reg);
    assign m_tuser  = out_clip_reg;

endmodule

`default_nettype wire

// ===== sv/biquad_iir_filter_checker.sv =====
// Port-level checker for the biquad IIR filter, bound to the top level.
// Depends on the top-level ports of biquad_iir_filter only.
`timescale 1ns / 1ps
`default_nettype none

module biquad_iir_filter_checker #(
    parameter int TDATA_W = 16
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tuser
);

    logic       s_xfer, m_xfer;
    logic [1:0] pend_reg, pend_next;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    // Samples accepted whose results have not yet been transferred out.
    always_comb begin
        pend_next = pend_reg;
        if (s_xfer && !m_xfer) begin
            pend_next = pend_reg + 2'd1;
        end else if (!s_xfer && m_xfer) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result shown with no sample pending");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |-> pend_reg == 2'd0 || pend_reg == 2'd1)
        else $error("sample accepted with two results pending");

    a_six_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready
                   ##1 !s_tready ##1 !s_tready)
        else $error("input accepted before the microprogram finished");

endmodule

bind biquad_iir_filter biquad_iir_filter_checker #(
    .TDATA_W (((SAMPLE_WIDTH + 7) / 8) * 8)
) u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the biquad IIR filter: streams samples through the section
// and compares every filtered sample and clip flag against an in-bench fixed-point model.
// Depends on biq_pkg and biquad_iir_filter.
`timescale 1ns / 1ps

module testbench
    import biq_pkg::*;
;

    localparam int SW = 16;                 // sample width of the instance
    localparam int FB = 16;                 // coefficient fraction bits
    localparam int DW = ((SW + 7) / 8) * 8; // stream data width

    // Fixed-point limits used by the prediction.
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint DELAY_MAX  = (longint'(1) <<< (DELAY_W - 1)) - 1;
    localparam longint DELAY_MIN  = -DELAY_MAX - 1;
    localparam longint ROUND_HALF = longint'(1) <<< (FB - 1);

    // Coefficient extremes and a few handy values.
    localparam logic signed [COEF_W-1:0] TAP_MAX  = 18'sh1FFFF;
    localparam logic signed [COEF_W-1:0] TAP_MIN  = 18'sh20000;
    localparam logic signed [COEF_W-1:0] TAP_ONE  = 18'sh10000;
    localparam logic signed [COEF_W-1:0] TAP_HALF = 18'sh08000;
    localparam logic signed [COEF_W-1:0] TAP_ZERO = 18'sh00000;

    // Register indexes that map to no coefficient; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam int STALL_PCT     = 36;   // idle probability of each side, in percent
    localparam int SETTLE_CYCLES = 16;   // lets the delay updates finish after the last result
    localparam int QUIET_LIMIT   = 4000; // cycles without any transfer before giving up
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 75;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [SW-1:0] sample;
        logic          clipped;
    } filt_result_t;

    // Clock, reset and DUT-facing signals. Every input is known from time zero.
    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [COEF_W-1:0]    cfg_wdata = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata   = '0;  // sample_in
    logic          s_tuser   = 1'b0; // block_start
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [DW-1:0] m_tdata;         // sample_out
    logic          m_tuser;         // clipped

    // Model of the filter state and its coefficients, in input order.
    longint tap_model [NUM_COEF];
    longint z1_model;
    longint z2_model;

    filt_result_t filtered_q[$]; // predicted results, oldest first

    int stall_pct    = STALL_PCT;
    int mismatches   = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int clipped_seen = 0;
    int block_starts = 0;
    int tap_writes   = 0;
    int quiet_cycles = 0;

    always #2 aclk = ~aclk;

    biquad_iir_filter #(
        .SAMPLE_WIDTH   (SW),
        .COEF_FRAC_BITS (FB)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clamps a value to [lo, hi] and tells whether it had to.
    function automatic longint clamp_to(input longint v, input longint lo, input longint hi,
                                        output logic hit);
        hit = 1'b0;
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        return v;
    endfunction

    // One step of the transposed direct form II section. The feedback taps see the
    // saturated output, and the rounding adds one half before the floor, so ties go up.
    function automatic filt_result_t biquad_predict(input logic signed [SW-1:0] x,
                                                    input logic block_start);
        filt_result_t res;
        longint xs, acc, y;
        logic   clip, ignored;
        xs = longint'(x);
        if (block_start) begin
            z1_model = 0;
            z2_model = 0;
        end
        acc = tap_model[COEF_B0] * xs + z1_model;
        y   = (acc + ROUND_HALF) >>> FB;
        y   = clamp_to(y, SAMPLE_MIN, SAMPLE_MAX, clip);
        z1_model = clamp_to(tap_model[COEF_B1] * xs + z2_model - tap_model[COEF_A1] * y,
                            DELAY_MIN, DELAY_MAX, ignored);
        z2_model = clamp_to(tap_model[COEF_B2] * xs - tap_model[COEF_A2] * y,
                            DELAY_MIN, DELAY_MAX, ignored);
        res.sample  = y[SW-1:0];
        res.clipped = clip;
        return res;
    endfunction

    // Offers one sample on the input stream and returns at the edge that accepts it.
    // Valid is only dropped when an idle gap is taken, so back-to-back transfers stay clean.
    task automatic send_sample(input logic signed [SW-1:0] x, input logic block_start);
        if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < stall_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DW'(x);
        s_tuser  <= block_start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        filtered_q.insert(filtered_q.size(), biquad_predict(x, block_start));
        samples_sent++;
        if (block_start) block_starts++;
    endtask

    // Quiets the input and waits until the section has finished all of its work,
    // including the delay updates that run after the result is handed out.
    task automatic settle_filter();
        s_tvalid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write. The enable is left high; the caller lowers it after a burst.
    task automatic write_tap(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx < NUM_COEF) tap_model[idx] = longint'($signed(val));
        tap_writes++;
    endtask

    task automatic load_taps(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
        settle_filter();
        write_tap(COEF_B0, b0);
        write_tap(COEF_B1, b1);
        write_tap(COEF_B2, b2);
        write_tap(COEF_A1, a1);
        write_tap(COEF_A2, a2);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [SW-1:0] random_sample();
        case ($urandom_range(9))
            0:       return SW'(SAMPLE_MAX);
            1:       return SW'(SAMPLE_MIN);
            2:       return SW'($signed($urandom_range(64)) - 32);
            default: return SW'($urandom);
        endcase
    endfunction

    // Full-range coefficient, or half the time a smaller one so that the outputs are
    // not always pinned to the rails.
    function automatic logic signed [COEF_W-1:0] random_tap();
        logic signed [COEF_W-1:0] t;
        t = COEF_W'($urandom);
        if ($urandom_range(1) == 1) t = t >>> $urandom_range(1, 4);
        return t;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Result checker: every transfer on the master side is compared with the oldest
    // prediction. Values are read as they stood at the edge.
    always @(posedge aclk) begin : check_results
        filt_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser) clipped_seen++;
            if (filtered_q.size() == 0) begin
                note_mismatch("unexpected result transfer", 0, 1);
            end else begin
                want = filtered_q.pop_front();
                if (m_tdata[SW-1:0] !== want.sample)
                    note_mismatch("sample_out", $signed(want.sample),
                                  $signed(m_tdata[SW-1:0]));
                if ((m_tdata >> SW) !== '0)
                    note_mismatch("m_tdata padding", 0, m_tdata >> SW);
                if (m_tuser !== want.clipped)
                    note_mismatch("clipped", want.clipped, m_tuser);
            end
        end
    end

    // The receiver stalls at random unless a no-stall stretch is running.
    always @(posedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, filtered_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // With reset coefficients (b0 of one, the rest zero) the section is a plain wire.
    task automatic test_unity_passthrough();
        send_sample(SW'(SAMPLE_MAX), 1'b1);
        send_sample(SW'(SAMPLE_MIN), 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0001, 1'b1);
        send_sample(-16'sh0001, 1'b0);
        send_sample(16'sh5555, 1'b0);
        send_sample(-16'sh5556, 1'b1);
    endtask

    // b0 of one half puts odd inputs exactly on a tie; ties must round toward plus infinity.
    task automatic test_rounding_ties();
        load_taps(TAP_HALF, TAP_ZERO, TAP_ZERO, TAP_ZERO, TAP_ZERO);
        send_sample(16'sh0001, 1'b1);
        send_sample(-16'sh0001, 1'b0);
        send_sample(16'sh0003, 1'b0);
        send_sample(-16'sh0003, 1'b0);
        send_sample(SW'(SAMPLE_MAX), 1'b0);
        send_sample(SW'(SAMPLE_MIN), 1'b0);
    endtask

    // Gains of nearly plus two and exactly minus two drive the output into both rails.
    task automatic test_saturation();
        load_taps(TAP_MAX, TAP_ZERO, TAP_ZERO, TAP_ZERO, TAP_ZERO);
        send_sample(SW'(SAMPLE_MAX), 1'b1);
        send_sample(SW'(SAMPLE_MIN), 1'b0);
        send_sample(16'sh4000, 1'b0);
        send_sample(16'sh0064, 1'b0);
        load_taps(TAP_MIN, TAP_ZERO, TAP_ZERO, TAP_ZERO, TAP_ZERO);
        send_sample(SW'(SAMPLE_MAX), 1'b0);
        send_sample(SW'(SAMPLE_MIN), 1'b0);
        send_sample(-16'sh4000, 1'b0);
    endtask

    // Extreme feedback and feedforward taps, with block starts cutting the history.
    // Writes to the unused register indexes 5 and 7 follow and must change nothing.
    task automatic test_feedback_extremes();
        load_taps(TAP_ONE, TAP_MAX, TAP_MIN, TAP_MIN, TAP_MAX);
        write_tap(CFG_IDX_SPARE_LO, '1);
        write_tap(CFG_IDX_SPARE_HI, TAP_MIN);
        cfg_wr_en <= 1'b0;
        send_sample(SW'(SAMPLE_MAX), 1'b1);
        send_sample(16'sh0000, 1'b0);
        send_sample(SW'(SAMPLE_MIN), 1'b0);
        send_sample(16'sh1234, 1'b0);
        send_sample(16'sh7000, 1'b1);
        send_sample(-16'sh7000, 1'b0);
        send_sample(16'sh0000, 1'b0);
    endtask

    // Random coefficient sets, each followed by a run of random samples. One phase runs
    // with no stalls on either side so that the section works at its full rate.
    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_taps(random_tap(), random_tap(), random_tap(), random_tap(), random_tap());
            stall_pct = (p == 3) ? 0 : STALL_PCT;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_sample(), (n == 0) || ($urandom_range(15) == 0));
        end
        stall_pct = STALL_PCT;
    endtask

    initial begin
        // Model state after reset matches the block: unity b0, everything else zero.
        foreach (tap_model[k]) tap_model[k] = 0;
        tap_model[COEF_B0] = longint'(TAP_ONE);
        z1_model = 0;
        z2_model = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unity_passthrough();
        test_rounding_ties();
        test_saturation();
        test_feedback_extremes();
        test_random_phases();

        // Drain: the queue empties as results arrive, then a short tail catches extras.
        settle_filter();

        $display("Filtered %0d samples (%0d block starts) over %0d register writes;",
                 samples_sent, block_starts, tap_writes);
        $display("checked %0d results, %0d of them clipped, %0d mismatches.",
                 results_seen, clipped_seen, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
